// File: sv/ssrl_pkg.sv
`timescale 1ns / 1ps
// Package for the servo slew-rate limiter: field widths, register indexes,
// opcodes, angle constants, the divide-by-180 reciprocal and the sequencer states.
// No dependencies.
package ssrl_pkg;

    localparam int MOTOR_COUNT_DEF   = 6;
    localparam int VEHICLE_INDEX_DEF = 5;

    // Stream and configuration port widths.
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Field widths.
    localparam int NOW_W   = 32;
    localparam int MOTOR_W = 3;
    localparam int ANGLE_W = 8;
    localparam int PULSE_W = 12;
    localparam int IVAL_W  = 16;
    localparam int ENTRY_W = 2 * ANGLE_W;

    // Opcodes carried in tuser.
    localparam logic OP_TIME   = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    // Configuration register indexes.
    localparam int REG_GROUP_INTERVAL   = 0;
    localparam int REG_VEHICLE_INTERVAL = 1;
    localparam int REG_LIMITS_BASE      = 2;

    localparam logic [IVAL_W-1:0]     INTERVAL_RESET = 16'd15;
    localparam logic [CFG_DATA_W-1:0] LIMITS_RESET   = 24'd2457750;

    localparam logic [ANGLE_W-1:0] FULL_SCALE_DEG   = 8'd180;
    localparam logic [ANGLE_W-1:0] VEHICLE_HOME_DEG = 8'd90;

    // floor(x / 180) == (x * RECIP_180) >> RECIP_SHIFT for every x below 2^20.
    localparam int PROD_W      = ANGLE_W + PULSE_W;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_180 = 21'd1491309;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_SCALE,
        ST_EMIT,
        ST_FLUSH,
        ST_TGT_WR
    } ssrl_state_t;

endpackage

// File: sv/servo_slew_rate_limiter.sv
`timescale 1ns / 1ps
// Servo slew-rate limiter: steps up to six servo channels toward their targets
// and emits a pulse width for each motor that moved.
// Depends on ssrl_pkg and ssrl_ram.
//
// The input stream carries two kinds of request, selected by s_tuser. A time
// request carries the millisecond clock in s_tdata; a target request carries a
// motor index and a target angle, which is clamped to 180 degrees. A target
// request produces no result. For an existing motor it holds the input through
// the target write state; any other index is dropped as it is accepted.
// A time request fires the group timer and the vehicle timer when the elapsed
// time (32-bit wrap) is strictly greater than their intervals. Every firing
// motor whose angle differs from its target moves one degree and produces one
// result request with its index and pulse width, in motor order with the vehicle
// motor last. m_tlast marks the final one; if nothing moves there is no result.
// Sequence: the sequencer visits one slot per motor. A slot whose timer did not
// fire is passed over, a motor that stays put has its angle read and compared,
// and a motor that moves goes through angle read, write back with the map
// multiply, reciprocal divide by 180 and hand-off; a closing state follows the
// last slot. A time request holds the input until the closing state is done;
// the slots run one after another, set by the single angle memory and the
// single shared pulse map unit. A result leaves once the next one is known, or
// in the closing state, so m_tlast can be marked. s_tready is high only
// while the sequencer is idle; a stalled receiver holds the sequencer at its next
// hand-off and no result is dropped. Reset (synchronous, active low) restores
// intervals and limits, clears the timestamps and marks every angle entry
// unwritten, so it reads as zero, or 90 degrees for the vehicle motor.
module servo_slew_rate_limiter #(
    parameter int MOTOR_COUNT   = ssrl_pkg::MOTOR_COUNT_DEF,
    parameter int VEHICLE_INDEX = ssrl_pkg::VEHICLE_INDEX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms [31:0], motor_index [34:32], target_degrees [42:35], zero above.
    input  logic [ssrl_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode [0].
    input  logic [ssrl_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // moved_motor [2:0], pulse_width [14:3], zero above.
    output logic [ssrl_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [ssrl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ssrl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ssrl_pkg::*;

    localparam int AW = $clog2(MOTOR_COUNT);
    localparam bit HAS_VEHICLE = (VEHICLE_INDEX < MOTOR_COUNT);
    localparam logic [AW-1:0] VEH_ADDR  = HAS_VEHICLE ? AW'(VEHICLE_INDEX) : '0;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MOTOR_COUNT - 1);

    // Input fields.
    logic [NOW_W-1:0]   s_now;
    logic [MOTOR_W-1:0] s_idx;
    logic [ANGLE_W-1:0] s_tgt;
    logic               s_op;

    assign s_now = s_tdata[NOW_W-1:0];
    assign s_idx = s_tdata[NOW_W +: MOTOR_W];
    assign s_tgt = s_tdata[NOW_W + MOTOR_W +: ANGLE_W];
    assign s_op  = s_tuser[0];

    // Control registers.
    ssrl_state_t          state_reg, state_next;
    logic [AW-1:0]        slot_reg, slot_next;
    logic                 gfire_reg, gfire_next;
    logic                 vfire_reg, vfire_next;
    logic                 gany_reg, gany_next;
    logic                 vmoved_reg, vmoved_next;
    logic                 held_valid_reg, held_valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [MOTOR_COUNT-1:0] entry_valid_reg, entry_valid_next;
    logic [IVAL_W-1:0]    group_int_reg, group_int_next;
    logic [IVAL_W-1:0]    veh_int_reg, veh_int_next;
    logic [CFG_DATA_W-1:0] limits_reg [MOTOR_COUNT];
    logic [CFG_DATA_W-1:0] limits_next [MOTOR_COUNT];
    logic [NOW_W-1:0]     group_last_reg, group_last_next;
    logic [NOW_W-1:0]     veh_last_reg, veh_last_next;

    // Payload registers.
    logic [NOW_W-1:0]     now_reg, now_next;
    logic [AW-1:0]        tgt_idx_reg, tgt_idx_next;
    logic [ANGLE_W-1:0]   tgt_val_reg, tgt_val_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 rd_vhome_reg, rd_vhome_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 neg_reg, neg_next;
    logic [PULSE_W-1:0]   lo_reg, lo_next;
    logic [PULSE_W-1:0]   q_reg, q_next;
    logic [MOTOR_W-1:0]   held_motor_reg, held_motor_next;
    logic [PULSE_W-1:0]   held_pulse_reg, held_pulse_next;
    logic [MOTOR_W-1:0]   m_motor_reg, m_motor_next;
    logic [PULSE_W-1:0]   m_pulse_reg, m_pulse_next;
    logic                 m_tlast_reg, m_tlast_next;

    // Angle memory: {target, current} per motor.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    ssrl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MOTOR_COUNT)
    ) u_angle_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Shared combinational terms.
    logic                 accept;
    logic                 out_free;
    logic                 last_slot;
    logic                 slot_active;
    logic [AW-1:0]        slot_addr;
    logic                 idx_ok;
    logic [ENTRY_W-1:0]   rd_entry;
    logic [ANGLE_W-1:0]   cur_angle;
    logic [ANGLE_W-1:0]   tgt_angle;
    logic                 moved;
    logic [ANGLE_W-1:0]   new_angle;
    logic [CFG_DATA_W-1:0] lim_sel;
    logic [PULSE_W-1:0]   lim_lo;
    logic [PULSE_W-1:0]   lim_hi;
    logic [PULSE_W-1:0]   lim_span;
    logic [NOW_W-1:0]     group_elapsed;
    logic [NOW_W-1:0]     veh_elapsed;
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [PULSE_W-1:0]   pulse_new;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_slot = (slot_reg == LAST_SLOT);
    assign idx_ok    = (s_idx < MOTOR_W'(MOTOR_COUNT));

    // The last slot serves the vehicle motor; the others serve the group, which
    // skips the vehicle index.
    assign slot_addr   = last_slot ? VEH_ADDR : slot_reg;
    assign slot_active = last_slot ? (HAS_VEHICLE && vfire_reg)
                                   : (gfire_reg && !(HAS_VEHICLE && slot_reg == VEH_ADDR));

    // An entry never written reads as its reset value.
    assign rd_entry  = rd_valid_reg ? ram_rdata
                     : (rd_vhome_reg ? {VEHICLE_HOME_DEG, VEHICLE_HOME_DEG} : '0);
    assign cur_angle = rd_entry[ANGLE_W-1:0];
    assign tgt_angle = rd_entry[ENTRY_W-1:ANGLE_W];
    assign moved     = (cur_angle != tgt_angle);
    assign new_angle = (cur_angle > tgt_angle) ? cur_angle - 1'b1 : cur_angle + 1'b1;

    assign lim_sel  = limits_reg[slot_addr];
    assign lim_lo   = lim_sel[PULSE_W-1:0];
    assign lim_hi   = lim_sel[CFG_DATA_W-1:PULSE_W];
    assign lim_span = (lim_hi >= lim_lo) ? lim_hi - lim_lo : lim_lo - lim_hi;

    assign group_elapsed = s_now - group_last_reg;
    assign veh_elapsed   = s_now - veh_last_reg;

    assign scaled    = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(RECIP_180);
    assign pulse_new = neg_reg ? lo_reg - q_reg : lo_reg + q_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_TIME) begin
                        state_next = ST_SCAN;
                    end else if (idx_ok) begin
                        state_next = ST_TGT_WR;
                    end
                end
            end
            ST_SCAN: begin
                if (slot_active) begin
                    state_next = ST_CALC;
                end else if (last_slot) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_CALC: begin
                if (moved) begin
                    state_next = ST_SCALE;
                end else begin
                    state_next = last_slot ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCALE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!held_valid_reg || out_free) begin
                    state_next = last_slot ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (!held_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TGT_WR: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and registers other than the state.
    always_comb begin
        slot_next        = slot_reg;
        gfire_next       = gfire_reg;
        vfire_next       = vfire_reg;
        gany_next        = gany_reg;
        vmoved_next      = vmoved_reg;
        held_valid_next  = held_valid_reg;
        entry_valid_next = entry_valid_reg;
        group_int_next   = group_int_reg;
        veh_int_next     = veh_int_reg;
        limits_next      = limits_reg;
        group_last_next  = group_last_reg;
        veh_last_next    = veh_last_reg;
        now_next         = now_reg;
        tgt_idx_next     = tgt_idx_reg;
        tgt_val_next     = tgt_val_reg;
        prod_next        = prod_reg;
        neg_next         = neg_reg;
        lo_next          = lo_reg;
        q_next           = q_reg;
        held_motor_next  = held_motor_reg;
        held_pulse_next  = held_pulse_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_motor_next     = m_motor_reg;
        m_pulse_next     = m_pulse_reg;
        m_tlast_next     = m_tlast_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_addr;
        ram_wdata = {tgt_angle, new_angle};
        ram_re    = 1'b0;
        ram_raddr = slot_addr;

        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = s_idx[AW-1:0];
                if (accept) begin
                    now_next     = s_now;
                    gfire_next   = group_elapsed > NOW_W'(group_int_reg);
                    vfire_next   = veh_elapsed > NOW_W'(veh_int_reg);
                    gany_next    = 1'b0;
                    vmoved_next  = 1'b0;
                    slot_next    = '0;
                    tgt_idx_next = s_idx[AW-1:0];
                    tgt_val_next = (s_tgt > FULL_SCALE_DEG) ? FULL_SCALE_DEG : s_tgt;
                    ram_re       = (s_op == OP_TARGET) && idx_ok;
                end
            end
            ST_SCAN: begin
                if (slot_active) begin
                    ram_re = 1'b1;
                end else if (!last_slot) begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_CALC: begin
                if (moved) begin
                    ram_we = 1'b1;
                    entry_valid_next[slot_addr] = 1'b1;
                    if (last_slot) begin
                        vmoved_next = 1'b1;
                    end else begin
                        gany_next = 1'b1;
                    end
                    prod_next = PROD_W'(new_angle) * PROD_W'(lim_span);
                    neg_next  = (lim_hi < lim_lo);
                    lo_next   = lim_lo;
                end else if (!last_slot) begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_SCALE: begin
                q_next = scaled[RECIP_SHIFT +: PULSE_W];
            end
            ST_EMIT: begin
                if (!held_valid_reg || out_free) begin
                    if (held_valid_reg) begin
                        m_tvalid_next = 1'b1;
                        m_motor_next  = held_motor_reg;
                        m_pulse_next  = held_pulse_reg;
                        m_tlast_next  = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_motor_next = MOTOR_W'(slot_addr);
                    held_pulse_next = pulse_new;
                    if (!last_slot) begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!held_valid_reg || out_free) begin
                    if (held_valid_reg) begin
                        m_tvalid_next   = 1'b1;
                        m_motor_next    = held_motor_reg;
                        m_pulse_next    = held_pulse_reg;
                        m_tlast_next    = 1'b1;
                        held_valid_next = 1'b0;
                    end
                    if (gany_reg) begin
                        group_last_next = now_reg;
                    end
                    if (vmoved_reg) begin
                        veh_last_next = now_reg;
                    end
                end
            end
            ST_TGT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = tgt_idx_reg;
                ram_wdata = {tgt_val_reg, cur_angle};
                entry_valid_next[tgt_idx_reg] = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase

        // The user must make configuration writes only while the block is idle; the block does not enforce it.
        if (cfg_we) begin
            if (cfg_index == CFG_INDEX_W'(REG_GROUP_INTERVAL)) begin
                group_int_next = cfg_wdata[IVAL_W-1:0];
            end
            if (cfg_index == CFG_INDEX_W'(REG_VEHICLE_INTERVAL)) begin
                veh_int_next = cfg_wdata[IVAL_W-1:0];
            end
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                if (cfg_index == CFG_INDEX_W'(REG_LIMITS_BASE + i)) begin
                    limits_next[i] = cfg_wdata;
                end
            end
        end
    end

    // Validity of the entry being read, captured alongside the memory output.
    assign rd_valid_next = entry_valid_reg[ram_raddr];
    assign rd_vhome_next = HAS_VEHICLE && (ram_raddr == VEH_ADDR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            slot_reg        <= '0;
            gfire_reg       <= 1'b0;
            vfire_reg       <= 1'b0;
            gany_reg        <= 1'b0;
            vmoved_reg      <= 1'b0;
            held_valid_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            entry_valid_reg <= '0;
            group_int_reg   <= INTERVAL_RESET;
            veh_int_reg     <= INTERVAL_RESET;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                limits_reg[i] <= LIMITS_RESET;
            end
            group_last_reg  <= '0;
            veh_last_reg    <= '0;
        end else begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            gfire_reg       <= gfire_next;
            vfire_reg       <= vfire_next;
            gany_reg        <= gany_next;
            vmoved_reg      <= vmoved_next;
            held_valid_reg  <= held_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
            entry_valid_reg <= entry_valid_next;
            group_int_reg   <= group_int_next;
            veh_int_reg     <= veh_int_next;
            limits_reg      <= limits_next;
            group_last_reg  <= group_last_next;
            veh_last_reg    <= veh_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg        <= now_next;
        tgt_idx_reg    <= tgt_idx_next;
        tgt_val_reg    <= tgt_val_next;
        rd_valid_reg   <= rd_valid_next;
        rd_vhome_reg   <= rd_vhome_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        lo_reg         <= lo_next;
        q_reg          <= q_next;
        held_motor_reg <= held_motor_next;
        held_pulse_reg <= held_pulse_next;
        m_motor_reg    <= m_motor_next;
        m_pulse_reg    <= m_pulse_next;
        m_tlast_reg    <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {1'b0, m_pulse_reg, m_motor_reg};

endmodule

// File: sv/ssrl_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ssrl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/ssrl_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the servo slew-rate limiter, bound to the top level.
// Depends on ssrl_pkg and servo_slew_rate_limiter.
module ssrl_checker #(
    parameter int MOTOR_COUNT = ssrl_pkg::MOTOR_COUNT_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [ssrl_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ssrl_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import ssrl_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // One request at a time: the block is busy right after accepting a time request.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == OP_TIME |=> !s_tready)
        else $error("request accepted while busy");

    // Only existing motors are reported.
    a_motor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[MOTOR_W-1:0] < MOTOR_W'(MOTOR_COUNT))
        else $error("result names a motor that does not exist");

endmodule

bind servo_slew_rate_limiter ssrl_checker #(
    .MOTOR_COUNT(MOTOR_COUNT)
) u_ssrl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
